// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that holds at every rising edge outside reset
`define CHK_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== hdl/ibl_pkg.sv =====
// constants, types and helpers of the image upscale blend block
package ibl_pkg;

    localparam int SRC_PIXELS = 65536;
    localparam int ADDR_W     = $clog2(SRC_PIXELS);

    localparam int DIM_W   = 13;
    localparam int COORD_W = 12;
    localparam int PIX_W   = 24;
    localparam int IDX_W   = 16;
    localparam int OUT_W   = 31;
    localparam int CHAN_W  = 8;

    localparam int DIV_STAGES = 12;
    localparam int QUO_W      = 12;
    localparam int DIVD_W     = 24;

    localparam int FRAC_SH = 11;
    localparam int MIX_SH  = 13;
    localparam int ACC_W   = 21;

    localparam logic [DIM_W-1:0]   DIM_MAX  = 13'd4096;
    localparam logic [FRAC_SH:0]   FRAC_ONE = 12'd2048;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              valid;
        t_cmd              cmd;
        logic [IDX_W-1:0]  load_index;
        logic [PIX_W-1:0]  src_pixel;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [ADDR_W-1:0] addr_n;
        logic [ADDR_W-1:0] addr_s;
        logic [ADDR_W-1:0] addr_d;
        logic [ADDR_W-1:0] addr_g;
    } t_fetch;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_MAX) begin
            res = DIM_MAX;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== hdl/ibl_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module ibl_div (
    input  logic                        i_clk,
    input  logic [ibl_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [ibl_pkg::DIM_W-1:0]   i_divisor,
    output logic [ibl_pkg::QUO_W-1:0]   o_quotient,
    output logic [ibl_pkg::DIM_W-1:0]   o_remainder
);
    import ibl_pkg::*;

    logic [DIM_W-1:0] r_rem [DIV_STAGES];
    logic [QUO_W-1:0] r_low [DIV_STAGES];
    logic [QUO_W-1:0] r_quo [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DIM_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] quo_in;
        logic [DIM_W:0]   trial;
        logic [DIM_W-1:0] n_rem;
        logic             qbit;

        if (k == 0) begin : g_first
            // upper dividend bits are below the divisor by construction
            assign rem_in = DIM_W'(i_dividend[DIVD_W-1:QUO_W]);
            assign low_in = i_dividend[QUO_W-1:0];
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign quo_in = r_quo[k-1];
        end

        always_comb begin
            trial = {rem_in, low_in[QUO_W-1]};
            qbit  = (trial >= {1'b0, i_divisor});
            n_rem = qbit ? DIM_W'(trial - {1'b0, i_divisor}) : DIM_W'(trial);
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_low[k] <= {low_in[QUO_W-2:0], 1'b0};
            r_quo[k] <= {quo_in[QUO_W-2:0], qbit};
        end
    end

    assign o_quotient  = r_quo[DIV_STAGES-1];
    assign o_remainder = r_rem[DIV_STAGES-1];

endmodule

// ===== hdl/ibl_ram.sv =====
// source image ram, one write port and two registered read ports
module ibl_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ibl_pkg::ADDR_W-1:0] i_waddr,
    input  logic [ibl_pkg::PIX_W-1:0]  i_wdata,
    input  logic [ibl_pkg::ADDR_W-1:0] i_raddr_a,
    input  logic [ibl_pkg::ADDR_W-1:0] i_raddr_b,
    output logic [ibl_pkg::PIX_W-1:0]  o_rdata_a,
    output logic [ibl_pkg::PIX_W-1:0]  o_rdata_b
);
    import ibl_pkg::*;

    logic [PIX_W-1:0] mem [SRC_PIXELS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// ===== hdl/image_upscale_blend.sv =====
// top level of the bilinear image upscale blend block
// one item is taken every clock (busy stays low) and a pixel command gives its
// strobe beat at the end of the pipeline; a load gives no beat. the pipeline runs
// through two 12-stage divider pipelines in series (cell mapping, then weights)
// then the ram read and the mix multiply. the receiver cannot stall, so every
// beat must be taken in the cycle it shows. size registers may only be written
// while no pixel is in flight. the source store has no clearing pass: every
// entry must be loaded before a pixel reads it
module image_upscale_blend (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_cmd,
    input  logic [ibl_pkg::IDX_W-1:0]    i_load_index,
    input  logic [ibl_pkg::PIX_W-1:0]    i_src_pixel,
    input  logic [ibl_pkg::COORD_W-1:0]  i_out_x,
    input  logic [ibl_pkg::COORD_W-1:0]  i_out_y,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [ibl_pkg::DIM_W-1:0]    i_cfg_data,
    output logic                         o_strobe,
    output logic [ibl_pkg::OUT_W-1:0]    o_encoded_pixel
);
    import ibl_pkg::*;

    // size registers
    logic [DIM_W-1:0] r_src_width, r_src_height, r_dst_width, r_dst_height;
    logic [DIM_W-1:0] sw, sh, dw, dh;

    // stage a: accepted command with clamped coordinates
    t_side              r_a_side, n_a_side;
    logic [COORD_W-1:0] r_a_x, r_a_y, n_a_x, n_a_y;

    // cell mapping dividers
    logic [COORD_W+DIM_W-1:0] prod_x, prod_y;
    logic [QUO_W-1:0]         q_x, q_y;
    logic [DIM_W-1:0]         rm_x, rm_y;
    t_side                    r_d1 [DIV_STAGES];

    // stage c: cell, neighbor columns and row bases
    t_side              r_c_side;
    logic [COORD_W-1:0] r_c_ax, r_c_ax1, n_c_ax1, n_c_ay1;
    logic [ADDR_W-1:0]  r_c_row0, r_c_row1;
    logic [DIM_W-1:0]   r_c_rx, r_c_ry;
    logic [COORD_W+DIM_W-1:0] row0_full, row1_full;

    // weight dividers
    logic [QUO_W-1:0] wq_x, wq_y;
    logic [DIM_W-1:0] wr_x, wr_y;
    t_fetch           r_d2 [DIV_STAGES];
    t_fetch           n_d2_in;
    t_fetch           e_item;

    // stage e: ram access and weight sums
    logic              ram_we;
    logic [FRAC_SH:0]  nx, ny, wx, wy;
    logic              r_f_valid;
    logic [DIM_W-1:0]  r_f_wn, r_f_ws, r_f_wd, r_f_wg;
    logic [PIX_W-1:0]  rd_n, rd_s, rd_d, rd_g;

    // stage g: blended color
    logic              r_g_valid;
    logic [PIX_W-1:0]  r_g_color, n_g_color;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= 13'd256;
            r_src_height <= 13'd256;
            r_dst_width  <= 13'd640;
            r_dst_height <= 13'd480;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data;
            endcase
        end
    end

    // out of range sizes act as the nearest legal size
    assign sw = sat_dim(r_src_width);
    assign sh = sat_dim(r_src_height);
    assign dw = sat_dim(r_dst_width);
    assign dh = sat_dim(r_dst_height);

    // accept and clamp coordinates to the destination frame
    always_comb begin
        n_a_side.valid      = i_start && !o_busy;
        n_a_side.cmd        = t_cmd'(i_cmd);
        n_a_side.load_index = i_load_index;
        n_a_side.src_pixel  = i_src_pixel;
        n_a_x = ({1'b0, i_out_x} > dw - 13'd1) ? COORD_W'(dw - 13'd1) : i_out_x;
        n_a_y = ({1'b0, i_out_y} > dh - 13'd1) ? COORD_W'(dh - 13'd1) : i_out_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side.valid <= 1'b0;
        end else begin
            r_a_side <= n_a_side;
        end
        r_a_x <= n_a_x;
        r_a_y <= n_a_y;
    end

    // x*sw / dw and y*sh / dh, product stays below 2^24
    assign prod_x = r_a_x * sw;
    assign prod_y = r_a_y * sh;

    ibl_div u_div_cx (
        .i_clk       (i_clk),
        .i_dividend  (prod_x[DIVD_W-1:0]),
        .i_divisor   (dw),
        .o_quotient  (q_x),
        .o_remainder (rm_x)
    );

    ibl_div u_div_cy (
        .i_clk       (i_clk),
        .i_dividend  (prod_y[DIVD_W-1:0]),
        .i_divisor   (dh),
        .o_quotient  (q_y),
        .o_remainder (rm_y)
    );

    // command info rides alongside the mapping dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_d1[k].valid <= 1'b0;
            end
        end else begin
            r_d1[0] <= r_a_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    // right and bottom neighbors clamp to the last column and row
    always_comb begin
        n_c_ax1 = (({1'b0, q_x} + 13'd1) < sw) ? q_x + 12'd1 : COORD_W'(sw - 13'd1);
        n_c_ay1 = (({1'b0, q_y} + 13'd1) < sh) ? q_y + 12'd1 : COORD_W'(sh - 13'd1);
        row0_full = q_y * sw;
        row1_full = n_c_ay1 * sw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side.valid <= 1'b0;
        end else begin
            r_c_side <= r_d1[DIV_STAGES-1];
        end
        r_c_ax   <= q_x;
        r_c_ax1  <= n_c_ax1;
        r_c_row0 <= row0_full[ADDR_W-1:0];
        r_c_row1 <= row1_full[ADDR_W-1:0];
        r_c_rx   <= rm_x;
        r_c_ry   <= rm_y;
    end

    // remainder scaled to 2048ths: rx*2048 / dw
    ibl_div u_div_wx (
        .i_clk       (i_clk),
        .i_dividend  (DIVD_W'({r_c_rx, {FRAC_SH{1'b0}}})),
        .i_divisor   (dw),
        .o_quotient  (wq_x),
        .o_remainder (wr_x)
    );

    ibl_div u_div_wy (
        .i_clk       (i_clk),
        .i_dividend  (DIVD_W'({r_c_ry, {FRAC_SH{1'b0}}})),
        .i_divisor   (dh),
        .o_quotient  (wq_y),
        .o_remainder (wr_y)
    );

    // neighbor addresses wrap modulo the store depth
    always_comb begin
        n_d2_in.side   = r_c_side;
        n_d2_in.addr_n = r_c_row0 + ADDR_W'(r_c_ax);
        n_d2_in.addr_s = r_c_row0 + ADDR_W'(r_c_ax1);
        n_d2_in.addr_d = r_c_row1 + ADDR_W'(r_c_ax);
        n_d2_in.addr_g = r_c_row1 + ADDR_W'(r_c_ax1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_d2[k].side.valid <= 1'b0;
            end
        end else begin
            r_d2[0] <= n_d2_in;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    assign e_item = r_d2[DIV_STAGES-1];

    // loads write at the same stage where pixels read, so program order holds
    // without forwarding
    assign ram_we = e_item.side.valid && (e_item.side.cmd == CMD_LOAD) &&
                    (32'(e_item.side.load_index) < SRC_PIXELS);

    // two copies of the store give four reads per clock
    ibl_ram u_ram_top (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ADDR_W'(e_item.side.load_index)),
        .i_wdata   (e_item.side.src_pixel),
        .i_raddr_a (e_item.addr_n),
        .i_raddr_b (e_item.addr_s),
        .o_rdata_a (rd_n),
        .o_rdata_b (rd_s)
    );

    ibl_ram u_ram_bot (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ADDR_W'(e_item.side.load_index)),
        .i_wdata   (e_item.side.src_pixel),
        .i_raddr_a (e_item.addr_d),
        .i_raddr_b (e_item.addr_g),
        .o_rdata_a (rd_d),
        .o_rdata_b (rd_g)
    );

    // (d-r)*2048/d equals 2048 minus the rounded-up r*2048/d
    always_comb begin
        wx = {1'b0, wq_x[FRAC_SH-1:0]};
        wy = {1'b0, wq_y[FRAC_SH-1:0]};
        nx = FRAC_ONE - wx - {{FRAC_SH{1'b0}}, (wr_x != '0)};
        ny = FRAC_ONE - wy - {{FRAC_SH{1'b0}}, (wr_y != '0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= e_item.side.valid && (e_item.side.cmd == CMD_PIXEL);
        end
        r_f_wn <= DIM_W'(nx) + DIM_W'(ny);
        r_f_ws <= DIM_W'(wx) + DIM_W'(ny);
        r_f_wd <= DIM_W'(nx) + DIM_W'(wy);
        r_f_wg <= DIM_W'(wx) + DIM_W'(wy);
    end

    // per channel weighted sum, truncated by 8192
    always_comb begin
        logic [ACC_W-1:0] acc;
        n_g_color = '0;
        for (int c = 0; c < 3; c++) begin
            acc = ACC_W'(rd_n[c*CHAN_W +: CHAN_W]) * ACC_W'(r_f_wn)
                + ACC_W'(rd_s[c*CHAN_W +: CHAN_W]) * ACC_W'(r_f_ws)
                + ACC_W'(rd_d[c*CHAN_W +: CHAN_W]) * ACC_W'(r_f_wd)
                + ACC_W'(rd_g[c*CHAN_W +: CHAN_W]) * ACC_W'(r_f_wg);
            n_g_color[c*CHAN_W +: CHAN_W] = acc[MIX_SH +: CHAN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else begin
            r_g_valid <= r_f_valid;
        end
        r_g_color <= n_g_color;
    end

    // flag bit on top of the color
    assign o_strobe        = r_g_valid;
    assign o_encoded_pixel = {1'b1, {(OUT_W-1-PIX_W){1'b0}}, r_g_color};

endmodule

// ===== hdl/ibl_checker.sv =====
// port level checker of the image upscale blend block and its bind
`include "assert_macros.svh"

module ibl_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic                         o_busy,
    input logic                         i_cmd,
    input logic [ibl_pkg::IDX_W-1:0]    i_load_index,
    input logic [ibl_pkg::PIX_W-1:0]    i_src_pixel,
    input logic [ibl_pkg::COORD_W-1:0]  i_out_x,
    input logic [ibl_pkg::COORD_W-1:0]  i_out_y,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready,
    input logic [1:0]                   i_cfg_index,
    input logic [ibl_pkg::DIM_W-1:0]    i_cfg_data,
    input logic                         o_strobe,
    input logic [ibl_pkg::OUT_W-1:0]    o_encoded_pixel
);
    import ibl_pkg::*;

    localparam int LATENCY = 28;

    // every beat carries the flag
    `CHK_IMPLY(a_flag_set, i_clk, i_rst_n, o_strobe, o_encoded_pixel[OUT_W-1], "flag missing")

    // bits between flag and color stay clear
    `CHK_IMPLY(a_gap_clear, i_clk, i_rst_n, o_strobe, o_encoded_pixel[OUT_W-2:PIX_W] == '0, "gap bits set")

    // a beat only follows a pixel command taken a fixed time before
    `CHK_IMPLY(a_beat_origin, i_clk, i_rst_n, o_strobe, $past(i_start && !o_busy && (i_cmd == CMD_PIXEL), LATENCY), "beat without pixel command")

endmodule

bind image_upscale_blend ibl_checker u_ibl_checker (.*);

// ===== bench/image_upscale_blend_test.sv =====
// self-checking testbench of the image upscale blend block
module image_upscale_blend_test;
    import ibl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // beats of a pixel come out at the end of the pipeline, so give some margin
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 115;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic                i_cmd;
    logic [IDX_W-1:0]    i_load_index;
    logic [PIX_W-1:0]    i_src_pixel;
    logic [COORD_W-1:0]  i_out_x;
    logic [COORD_W-1:0]  i_out_y;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [DIM_W-1:0]    i_cfg_data;
    logic                o_strobe;
    logic [OUT_W-1:0]    o_encoded_pixel;

    image_upscale_blend dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_cmd           (i_cmd),
        .i_load_index    (i_load_index),
        .i_src_pixel     (i_src_pixel),
        .i_out_x         (i_out_x),
        .i_out_y         (i_out_y),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_encoded_pixel (o_encoded_pixel)
    );

    // shadow copy of the size registers and of the source store
    logic [DIM_W-1:0]  size_reg [4];
    logic [PIX_W-1:0]  src_image [SRC_PIXELS];
    bit                src_loaded [SRC_PIXELS];

    // colors still owed by the block, oldest first
    logic [OUT_W-1:0]  pending_colors [$];
    int                mismatches;
    int                stall_cycles;
    int                items_sent;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // clamp a size register into 1..4096 as the block does
    function automatic int unsigned clamp_size(logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > 13'd4096) return 4096;
        return 32'(v);
    endfunction

    // the four neighbor addresses (n, s, d, g) and the blend weights of a pixel
    function automatic void map_cell(input int unsigned x_in, input int unsigned y_in,
                                     output int unsigned addr [4],
                                     output int unsigned wt [4]);
        int unsigned sw, sh, dw, dh, x, y, ax, ay, rx, ry, ax1, ay1;
        sw = clamp_size(size_reg[CFG_SRC_WIDTH]);
        sh = clamp_size(size_reg[CFG_SRC_HEIGHT]);
        dw = clamp_size(size_reg[CFG_DST_WIDTH]);
        dh = clamp_size(size_reg[CFG_DST_HEIGHT]);
        // coordinates beyond the destination stick to its last row / column
        x = (x_in > dw - 1) ? dw - 1 : x_in;
        y = (y_in > dh - 1) ? dh - 1 : y_in;
        ax = x * sw / dw;
        rx = x * sw % dw;
        ay = y * sh / dh;
        ry = y * sh % dh;
        // right and bottom neighbors clamp to the source edge
        ax1 = (ax + 1 < sw) ? ax + 1 : sw - 1;
        ay1 = (ay + 1 < sh) ? ay + 1 : sh - 1;
        // linear addresses wrap around the store
        addr[0] = (ay * sw + ax) % SRC_PIXELS;
        addr[1] = (ay * sw + ax1) % SRC_PIXELS;
        addr[2] = (ay1 * sw + ax) % SRC_PIXELS;
        addr[3] = (ay1 * sw + ax1) % SRC_PIXELS;
        // weights in 2048ths: wx, nx, wy, ny
        wt[0] = rx * 2048 / dw;
        wt[1] = (dw - rx) * 2048 / dw;
        wt[2] = ry * 2048 / dh;
        wt[3] = (dh - ry) * 2048 / dh;
    endfunction

    function automatic logic [OUT_W-1:0] blend_color(int unsigned x, int unsigned y);
        int unsigned addr [4];
        int unsigned wt [4];
        int unsigned sum;
        logic [OUT_W-1:0] color;
        map_cell(x, y, addr, wt);
        color = 31'h4000_0000;
        for (int c = 0; c < 3; c++) begin
            sum = src_image[addr[0]][c*8 +: 8] * (wt[1] + wt[3])
                + src_image[addr[1]][c*8 +: 8] * (wt[0] + wt[3])
                + src_image[addr[2]][c*8 +: 8] * (wt[1] + wt[2])
                + src_image[addr[3]][c*8 +: 8] * (wt[0] + wt[2]);
            color[c*8 +: 8] = 8'(sum / 8192);
        end
        return color;
    endfunction

    // one beat on the command side, sometimes followed by a random gap
    task automatic send_item(t_cmd cmd, logic [IDX_W-1:0] idx, logic [PIX_W-1:0] pix,
                             logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        int pick;
        i_start      <= 1'b1;
        i_cmd        <= cmd;
        i_load_index <= idx;
        i_src_pixel  <= pix;
        i_out_x      <= x;
        i_out_y      <= y;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        // taken at this edge
        items_sent++;
        if (cmd == CMD_LOAD) begin
            src_image[idx]  = pix;
            src_loaded[idx] = 1'b1;
        end else begin
            pending_colors.push_back(blend_color(32'(x), 32'(y)));
        end
        pick = $urandom_range(0, 99);
        if (pick >= 60) begin
            i_start <= 1'b0;
            repeat (pick >= 95 ? $urandom_range(10, 40) : $urandom_range(1, 3))
                @(posedge i_clk);
        end
    endtask

    // pixel beat, preceded by loads of any neighbor that was never written
    task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        int unsigned addr [4];
        int unsigned wt [4];
        map_cell(32'(x), 32'(y), addr, wt);
        for (int k = 0; k < 4; k++) begin
            if (!src_loaded[addr[k]]) begin
                send_item(CMD_LOAD, IDX_W'(addr[k]), PIX_W'($urandom), '0, '0);
            end
        end
        send_item(CMD_PIXEL, IDX_W'($urandom), PIX_W'($urandom), x, y);
    endtask

    // wait until no pixel is in flight and the pipeline has drained
    task automatic wait_idle();
        i_start <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(t_cfg_idx idx, logic [DIM_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        size_reg[idx] = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh,
                             logic [DIM_W-1:0] dw, logic [DIM_W-1:0] dh);
        wait_idle();
        write_size(CFG_SRC_WIDTH, sw);
        write_size(CFG_SRC_HEIGHT, sh);
        write_size(CFG_DST_WIDTH, dw);
        write_size(CFG_DST_HEIGHT, dh);
    endtask

    // corners, interior and out-of-range coordinates at one setting
    task automatic probe_corners();
        send_pixel('0, '0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hFFF, '0);
        send_pixel(12'd1, 12'hFFF);
        send_pixel(12'hAAA, 12'h555);
    endtask

    // reset sizes 256x256 -> 640x480, plus two loads with no beat
    task automatic test_reset_sizes();
        send_item(CMD_LOAD, 16'hFFFF, 24'hFFFFFF, 12'hFFF, 12'hFFF);
        send_item(CMD_LOAD, 16'h0000, 24'h000000, '0, '0);
        probe_corners();
        send_pixel(12'd320, 12'd240);
    endtask

    // smallest, largest, zero and over-range sizes
    task automatic test_size_extremes();
        set_sizes(13'd1, 13'd1, 13'd1, 13'd1);
        probe_corners();
        // large source: addresses wrap around the store
        set_sizes(13'd4096, 13'd4096, 13'd4096, 13'd4096);
        probe_corners();
        // zero acts as one, above 4096 acts as 4096
        set_sizes(13'd0, 13'h1FFF, 13'h1FFF, 13'd0);
        probe_corners();
        set_sizes(13'h1FFF, 13'd0, 13'd3, 13'd4096);
        probe_corners();
    endtask

    function automatic logic [DIM_W-1:0] random_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return DIM_W'($urandom_range(1, 64));
        if (pick < 90) return DIM_W'($urandom_range(1, 4096));
        return DIM_W'($urandom_range(0, 8191));
    endfunction

    // random sizes, mostly pixels with random content, some stray loads
    task automatic test_random_mix();
        int unsigned dw, dh;
        int          phase_end;
        for (int phase = 0; phase < 8; phase++) begin
            set_sizes(random_size(), random_size(), random_size(), random_size());
            dw = clamp_size(size_reg[CFG_DST_WIDTH]);
            dh = clamp_size(size_reg[CFG_DST_HEIGHT]);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 20) begin
                    send_item(CMD_LOAD, IDX_W'($urandom), PIX_W'($urandom),
                              COORD_W'($urandom), COORD_W'($urandom));
                end else if ($urandom_range(0, 99) < 85) begin
                    send_pixel(COORD_W'($urandom_range(0, dw - 1)),
                               COORD_W'($urandom_range(0, dh - 1)));
                end else begin
                    send_pixel(COORD_W'($urandom), COORD_W'($urandom));
                end
            end
        end
    endtask

    // result side: one beat per strobe cycle, compared with the oldest color owed
    always @(negedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_strobe) begin
            if (pending_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: got %h", o_encoded_pixel);
            end else begin
                want = pending_colors.pop_front();
                if (o_encoded_pixel !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("color mismatch: expected %h got %h", want,
                                 o_encoded_pixel);
                end
            end
        end
    end

    // watchdog on cycles with no beat of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        items_sent   = 0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_cmd        = 1'b0;
        i_load_index = '0;
        i_src_pixel  = '0;
        i_out_x      = '0;
        i_out_y      = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        size_reg[CFG_SRC_WIDTH]  = 13'd256;
        size_reg[CFG_SRC_HEIGHT] = 13'd256;
        size_reg[CFG_DST_WIDTH]  = 13'd640;
        size_reg[CFG_DST_HEIGHT] = 13'd480;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_sizes();
        test_size_extremes();
        test_random_mix();

        wait_idle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
